FILE: design/basic_line_tokenizer_top_macros.svh
// Assertion macros shared by the line tokenizer modules.
// Needs signals named clk and rst_n in the module that uses them.
`ifndef BASIC_LINE_TOKENIZER_TOP_MACROS_SVH
`define BASIC_LINE_TOKENIZER_TOP_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define BLTK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BLTK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BLTK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/bltk_pkg.sv
// Shared types, constants and keyword tables of the line tokenizer.
// No dependencies; every module of the block imports this package.
package bltk_pkg;

  // Sizes of the line and of the kept word prefix.
  localparam int LINE_MAX    = 1024;
  localparam int KEYWORD_LEN = 6;
  localparam int POS_W       = $clog2(LINE_MAX);
  localparam int LP_W        = $clog2(LINE_MAX + 1);
  localparam int WC_W        = $clog2(KEYWORD_LEN + 1);

  // Field widths of a result item.
  localparam int KIND_W  = 5;
  localparam int START_W = 10;
  localparam int LEN_W   = 11;
  localparam int VAL_W   = 31;
  localparam int CHAR_W  = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int SLOTS       = 3;

  localparam logic [VAL_W-1:0] NUM_MAX = {VAL_W{1'b1}};

  // Token kind codes.
  localparam logic [KIND_W-1:0] KIND_EOL     = 5'd0;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd1;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd2;
  localparam logic [KIND_W-1:0] KIND_STAR    = 5'd3;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_EQUAL   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_LESS    = 5'd6;
  localparam logic [KIND_W-1:0] KIND_GREATER = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd8;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd9;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd10;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd11;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd12;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd13;
  localparam logic [KIND_W-1:0] KIND_KW0     = 5'd14;
  localparam int                KW_COUNT     = 18;
  localparam int                KW_REM_INDEX = 11;
  localparam logic [KIND_W-1:0] KIND_REM     = KIND_W'(14 + KW_REM_INDEX);

  // Character codes with special meaning.
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;

  // One result item.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic [VAL_W-1:0]   value;
    logic               ovf;
    logic [CHAR_W-1:0]  ch;
  } tok_t;

  // All results caused by one input item, in order; cnt is 1 to 3.
  typedef struct packed {
    tok_t [SLOTS-1:0] toks;
    logic [1:0]       cnt;
  } bundle_t;

  // Keyword text, first character in the highest used byte.
  function automatic logic [KEYWORD_LEN*8-1:0] kw_text(input int k);
    logic [KEYWORD_LEN*8-1:0] t;
    case (k)
      0:       t = "LET";
      1:       t = "PRINT";
      2:       t = "INPUT";
      3:       t = "GOTO";
      4:       t = "IF";
      5:       t = "THEN";
      6:       t = "END";
      7:       t = "FOR";
      8:       t = "TO";
      9:       t = "STEP";
      10:      t = "NEXT";
      11:      t = "REM";
      12:      t = "LIST";
      13:      t = "CLEAR";
      14:      t = "RUN";
      15:      t = "QUIT";
      16:      t = "INDENT";
      17:      t = "DEDENT";
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [WC_W-1:0] kw_len(input int k);
    logic [WC_W-1:0] n;
    case (k)
      1, 2, 13:              n = WC_W'(5);
      3, 5, 9, 10, 12, 15:   n = WC_W'(4);
      4, 8:                  n = WC_W'(2);
      16, 17:                n = WC_W'(6);
      0, 6, 7, 11, 14:       n = WC_W'(3);
      default:               n = '0;
    endcase
    return n;
  endfunction

  // Kind of a finished word; prefix byte i sits at bits [i*8 +: 8].
  function automatic logic [KIND_W-1:0] word_kind(input logic [KEYWORD_LEN*8-1:0] pfx,
                                                  input logic [WC_W-1:0] cnt,
                                                  input logic too_long);
    logic [KIND_W-1:0]        kind;
    logic                     hit;
    logic [KEYWORD_LEN*8-1:0] txt;
    logic [WC_W-1:0]          len;
    int                       pos;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      txt = kw_text(k);
      len = kw_len(k);
      hit = (len == cnt) && !too_long;
      for (int i = 0; i < KEYWORD_LEN; i++) begin
        if (i < int'(len)) begin
          pos = int'(len) - 1 - i;
          if (pfx[i*8 +: 8] != txt[pos*8 +: 8]) begin
            hit = 1'b0;
          end
        end
      end
      if (hit && kind == KIND_IDENT) begin
        kind = KIND_W'(int'(KIND_KW0) + k);
      end
    end
    return kind;
  endfunction

  // Punctuation kind of a character, or the unknown kind.
  function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
    logic [KIND_W-1:0] kind;
    case (c)
      "+":     kind = KIND_PLUS;
      "-":     kind = KIND_MINUS;
      "*":     kind = KIND_STAR;
      "/":     kind = KIND_SLASH;
      "=":     kind = KIND_EQUAL;
      "<":     kind = KIND_LESS;
      ">":     kind = KIND_GREATER;
      "(":     kind = KIND_LPAREN;
      ")":     kind = KIND_RPAREN;
      ",":     kind = KIND_COMMA;
      default: kind = KIND_UNKNOWN;
    endcase
    return kind;
  endfunction

endpackage

FILE: design/bltk_front.sv
// Front end of the line tokenizer: accepts characters, keeps the scanner
// state and pushes the results of each item as one bundle. Uses bltk_pkg.
module bltk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  input  logic              in_has_char,
  input  logic              in_end_of_line,
  output logic              push_valid,
  input  logic              push_ready,
  output bltk_pkg::bundle_t push_data
);
  import bltk_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;
  localparam logic [1:0] MODE_REM  = 2'd3;

  logic [1:0]       mode_r, mode_nxt;
  logic [LP_W-1:0]  lp_r, lp_nxt;
  logic [POS_W-1:0] tb_r, tb_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [WC_W-1:0]  wc_r, wc_nxt;
  logic             tl_r, tl_nxt;
  logic [7:0]       prefix_r [KEYWORD_LEN];

  logic                     accept;
  logic                     has_ok, is_dig, is_let, is_wchar, is_sep;
  logic                     word_app, start_word;
  logic [7:0]               prefix_upd [KEYWORD_LEN];
  logic [KEYWORD_LEN*8-1:0] prefix_flat;
  logic [WC_W-1:0]          wc_upd;
  logic                     tl_upd;
  logic [KIND_W-1:0]        kind;
  logic [VAL_W+3:0]         acc_x10;
  logic                     taken;
  tok_t                     cand [4];
  logic [3:0]               cand_v;
  bundle_t                  bundle;
  logic [1:0]               n;

  function automatic tok_t mk_tok(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] s,
                                  input logic [LEN_W-1:0] l, input logic [VAL_W-1:0] v,
                                  input logic o, input logic [7:0] c);
    tok_t t;
    t.kind  = k;
    t.start = START_W'(s);
    t.len   = l;
    t.value = v;
    t.ovf   = o;
    t.ch    = c;
    return t;
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // Character classes.
  assign has_ok   = in_has_char && (lp_r < LP_W'(LINE_MAX));
  assign is_dig   = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_let   = ((in_char_code >= "A") && (in_char_code <= "Z")) ||
                    ((in_char_code >= "a") && (in_char_code <= "z"));
  assign is_wchar = is_let || is_dig || (in_char_code == CH_UNDERSCORE);
  assign is_sep   = (in_char_code == CH_SPACE) || (in_char_code == CH_TAB) ||
                    (in_char_code == CH_CR);

  // Word state after this character, used for keyword matching and storage.
  assign word_app   = has_ok && (mode_r == MODE_WORD) && is_wchar;
  assign start_word = has_ok && is_let && ((mode_r == MODE_IDLE) || (mode_r == MODE_NUM));

  always_comb begin
    wc_upd = wc_r;
    tl_upd = tl_r;
    for (int i = 0; i < KEYWORD_LEN; i++) begin
      prefix_upd[i] = prefix_r[i];
    end
    if (start_word) begin
      prefix_upd[0] = in_char_code;
      wc_upd        = WC_W'(1);
      tl_upd        = 1'b0;
    end else if (word_app) begin
      if (wc_r < WC_W'(KEYWORD_LEN)) begin
        for (int i = 0; i < KEYWORD_LEN; i++) begin
          if (wc_r == WC_W'(i)) begin
            prefix_upd[i] = in_char_code;
          end
        end
        wc_upd = wc_r + WC_W'(1);
      end else begin
        tl_upd = 1'b1;
      end
    end
    for (int i = 0; i < KEYWORD_LEN; i++) begin
      prefix_flat[i*8 +: 8] = prefix_upd[i];
    end
  end

  assign kind = word_kind(prefix_flat, wc_upd, tl_upd);

  // Accumulator times ten plus the new digit.
  assign acc_x10 = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                   (VAL_W+4)'(in_char_code[3:0]);

  // Scanner step and result candidates in output order.
  always_comb begin
    mode_nxt  = mode_r;
    lp_nxt    = lp_r;
    tb_nxt    = tb_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    wc_nxt    = wc_upd;
    tl_nxt    = tl_upd;
    taken     = 1'b0;
    cand_v    = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    cand[3].kind = KIND_EOL;

    if (has_ok) begin
      case (mode_r)
        MODE_NUM: begin
          if (is_dig) begin
            if (acc_x10 > (VAL_W+4)'(NUM_MAX)) begin
              acc_nxt = NUM_MAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_x10[VAL_W-1:0];
            end
            taken = 1'b1;
          end else begin
            cand_v[0] = 1'b1;
            cand[0]   = mk_tok(KIND_NUMBER, tb_r, LEN_W'(lp_r - LP_W'(tb_r)), acc_r, ovf_r,
                               '0);
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          if (is_wchar) begin
            taken = 1'b1;
          end else if (kind == KIND_REM) begin
            mode_nxt = MODE_REM;
            tb_nxt   = lp_r[POS_W-1:0];
            taken    = 1'b1;
          end else begin
            cand_v[0] = 1'b1;
            cand[0]   = mk_tok(kind, tb_r, LEN_W'(lp_r - LP_W'(tb_r)), '0, 1'b0, '0);
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_REM: begin
          taken = 1'b1;
        end
        default: begin
        end
      endcase

      if (!taken) begin
        if (is_sep) begin
          // Separators only end tokens.
        end else if (is_dig) begin
          mode_nxt = MODE_NUM;
          tb_nxt   = lp_r[POS_W-1:0];
          acc_nxt  = VAL_W'(in_char_code[3:0]);
          ovf_nxt  = 1'b0;
        end else if (is_let) begin
          mode_nxt = MODE_WORD;
          tb_nxt   = lp_r[POS_W-1:0];
        end else begin
          cand_v[1] = 1'b1;
          cand[1]   = mk_tok(punct_kind(in_char_code), lp_r[POS_W-1:0], LEN_W'(1), '0,
                             1'b0, in_char_code);
        end
      end
      lp_nxt = lp_r + LP_W'(1);
    end

    // Line end flushes the open token, then gives the end-of-line token.
    if (in_end_of_line) begin
      case (mode_nxt)
        MODE_NUM: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_tok(KIND_NUMBER, tb_nxt, LEN_W'(lp_nxt - LP_W'(tb_nxt)), acc_nxt,
                             ovf_nxt, '0);
        end
        MODE_WORD: begin
          cand_v[2] = 1'b1;
          if (kind == KIND_REM) begin
            cand[2] = mk_tok(KIND_REM,
                             (lp_nxt < LP_W'(LINE_MAX)) ? lp_nxt[POS_W-1:0]
                                                        : POS_W'(LINE_MAX - 1),
                             '0, '0, 1'b0, '0);
          end else begin
            cand[2] = mk_tok(kind, tb_nxt, LEN_W'(lp_nxt - LP_W'(tb_nxt)), '0, 1'b0, '0);
          end
        end
        MODE_REM: begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_tok(KIND_REM, tb_nxt, LEN_W'(lp_nxt - LP_W'(tb_nxt)), '0, 1'b0,
                             '0);
        end
        default: begin
        end
      endcase
      cand_v[3] = 1'b1;
      mode_nxt  = MODE_IDLE;
      lp_nxt    = '0;
      tb_nxt    = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      wc_nxt    = '0;
      tl_nxt    = 1'b0;
    end
  end

  // Pack the valid candidates into the bundle slots.
  always_comb begin
    bundle = '0;
    n      = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (n < 2'(SLOTS))) begin
        bundle.toks[n] = cand[i];
        n              = n + 2'd1;
      end
    end
    bundle.cnt = n;
  end

  assign push_valid = accept && (n != 2'd0);
  assign push_data  = bundle;

  // Scanner control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      lp_r   <= '0;
      tb_r   <= '0;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
      wc_r   <= '0;
      tl_r   <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      lp_r   <= lp_nxt;
      tb_r   <= tb_nxt;
      acc_r  <= acc_nxt;
      ovf_r  <= ovf_nxt;
      wc_r   <= wc_nxt;
      tl_r   <= tl_nxt;
    end
  end

  // Word prefix bytes; only entries below the word count are ever read.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < KEYWORD_LEN; i++) begin
        prefix_r[i] <= prefix_upd[i];
      end
    end
  end

endmodule

FILE: design/bltk_fifo.sv
// Short queue of result bundles between the tokenizer front and back ends.
// Uses bltk_pkg for the bundle type and depth.
module bltk_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  bltk_pkg::bundle_t push_data,
  output logic              head_valid,
  output bltk_pkg::bundle_t head_data,
  input  logic              pop
);
  import bltk_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bundle_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r, rptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok, pop_ok;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rptr_r];
  assign push_ok    = push_valid && push_ready;
  assign pop_ok     = pop && head_valid;

  // Storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push_ok) begin
        wptr_r <= (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rptr_r <= (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`include "basic_line_tokenizer_top_macros.svh"

  `BLTK_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
  `BLTK_ASSERT_IMP(a_empty_ptrs, count_r == '0, wptr_r == rptr_r, "empty queue, pointers differ")
  `BLTK_ASSERT_NXT(a_count_up, push_ok && !pop_ok, count_r == $past(count_r) + CNT_W'(1), "count missed a push")

endmodule

FILE: design/bltk_back.sv
// Back end of the line tokenizer: sends the results of the head bundle one
// per cycle on the output channel while out_ready is high. Uses bltk_pkg.
module bltk_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                head_valid,
  input  bltk_pkg::bundle_t                   head_data,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bltk_pkg::KIND_W-1:0]         out_token_kind,
  output logic [bltk_pkg::START_W-1:0]        out_token_start,
  output logic [bltk_pkg::LEN_W-1:0]          out_token_length,
  output logic [bltk_pkg::VAL_W-1:0]          out_number_value,
  output logic                                out_number_overflow,
  output logic [bltk_pkg::CHAR_W-1:0]         out_char_echo,
  output logic                                out_last_of_run
);
  import bltk_pkg::*;

  logic [1:0] idx_r;
  tok_t       tok;
  logic       last;
  logic       fire;

  assign tok  = head_data.toks[idx_r];
  assign last = (idx_r == head_data.cnt - 2'd1);
  assign fire = out_valid && out_ready;
  assign pop  = fire && last;

  assign out_valid           = head_valid;
  assign out_token_kind      = tok.kind;
  assign out_token_start     = tok.start;
  assign out_token_length    = tok.len;
  assign out_number_value    = tok.value;
  assign out_number_overflow = tok.ovf;
  assign out_char_echo       = tok.ch;
  assign out_last_of_run     = last;

  // Slot index within the head bundle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (fire) begin
      idx_r <= last ? 2'd0 : idx_r + 2'd1;
    end
  end

`include "basic_line_tokenizer_top_macros.svh"

  `BLTK_ASSERT_IMP(a_idx_in_range, head_valid, idx_r < head_data.cnt, "slot index past bundle")
  `BLTK_ASSERT_IMP(a_cnt_nonzero, head_valid, head_data.cnt != 2'd0, "empty bundle in queue")
  `BLTK_ASSERT_NXT(a_idx_step, fire && !last, idx_r == $past(idx_r) + 2'd1, "slot index did not step")

endmodule

FILE: design/basic_line_tokenizer_top.sv
// Line tokenizer, top level: front end, bundle queue and back end.
// Depends on bltk_pkg, bltk_front, bltk_fifo and bltk_back.
//
// Use: characters of one line enter on the in_ channel (valid/ready), one
// item per cycle while in_ready is high. has_char marks a real character;
// end_of_line closes the line, flushes the open token and adds an
// end-of-line token. Tokens leave on the out_ channel (valid/ready), one per
// cycle while out_ready is high, with last_of_run set on the last token
// caused by an item. An item gives zero to three tokens; these are written
// to the bundle queue when the item is accepted and offered from its head.
// Items are taken one per cycle while the results fit the output rate; an
// item with three tokens holds the back end until all three are sent. A
// four-bundle queue lets the front keep taking items while the receiver
// stalls; in_ready drops only when that queue is full. Reset clears the
// scanner state and empties the queue; no clearing pass is needed.
module basic_line_tokenizer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_char_code,
  input  logic                         in_has_char,
  input  logic                         in_end_of_line,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bltk_pkg::KIND_W-1:0]  out_token_kind,
  output logic [bltk_pkg::START_W-1:0] out_token_start,
  output logic [bltk_pkg::LEN_W-1:0]   out_token_length,
  output logic [bltk_pkg::VAL_W-1:0]   out_number_value,
  output logic                         out_number_overflow,
  output logic [bltk_pkg::CHAR_W-1:0]  out_char_echo,
  output logic                         out_last_of_run
);
  import bltk_pkg::*;

  logic    push_valid, push_ready;
  bundle_t push_data;
  logic    head_valid;
  bundle_t head_data;
  logic    pop;

  // Character scanner.
  bltk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_has_char    (in_has_char),
    .in_end_of_line (in_end_of_line),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  // Bundle queue.
  bltk_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  // Token output.
  bltk_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_data           (head_data),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_token_start     (out_token_start),
    .out_token_length    (out_token_length),
    .out_number_value    (out_number_value),
    .out_number_overflow (out_number_overflow),
    .out_char_echo       (out_char_echo),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
